/* hw/rtl/sjf_pkg.sv */
// Package for the non-preemptive shortest-job-first scheduler.
// Holds the table depth, derived widths and the state encoding.
// No dependencies.
package sjf_pkg;

    localparam int MAX_PROCS = 32;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TIME_W    = 22;
    localparam int FIELD_W   = 16;
    localparam int PIDX_W    = 5;

    typedef enum logic [2:0] {
        ST_LOAD   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_DECIDE = 3'b100
    } sjf_state_t;

    typedef struct packed {
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
    } sjf_entry_t;

endpackage

/* hw/rtl/nonpreemptive_sjf_scheduler_unit.sv */
// Non-preemptive shortest-job-first scheduler; depends on sjf_pkg. Loads a process
// table at one word a cycle, then emits one result word per process in run order.
// Each decision is a scan of the table RAM (one read a cycle, read data registered) plus
// a decide state, and a further scan for each jump of time to the next arrival;
// input stalls until the set's last result is issued.
// Reset is synchronous, active low, clears control state and done flags, not the RAM.
module nonpreemptive_sjf_scheduler_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sjf_pkg::FIELD_W-1:0]   s_arrival_time,
    input  logic [sjf_pkg::FIELD_W-1:0]   s_burst_time,
    input  logic                          s_last_process,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sjf_pkg::PIDX_W-1:0]    m_process_index,
    output logic [sjf_pkg::TIME_W-1:0]    m_completion_time,
    output logic [sjf_pkg::TIME_W-1:0]    m_turnaround_time,
    output logic [sjf_pkg::TIME_W-1:0]    m_waiting_time,
    output logic                          m_last_result
);
    import sjf_pkg::*;

    sjf_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       loaded_reg, loaded_next;
    logic [CNT_W-1:0]       finished_reg, finished_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [MAX_PROCS-1:0]   done_reg, done_next;
    logic [CNT_W-1:0]       issue_reg, issue_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   found_reg, found_next;
    logic                   any_reg, any_next;
    logic [IDX_W-1:0]       pick_reg, pick_next;
    logic [FIELD_W-1:0]     best_bur_reg, best_bur_next;
    logic [FIELD_W-1:0]     best_arr_reg, best_arr_next;
    logic [FIELD_W-1:0]     earliest_reg, earliest_next;

    logic                   m_valid_reg, m_valid_next;
    logic [PIDX_W-1:0]      pidx_reg, pidx_next;
    logic [TIME_W-1:0]      comp_reg, comp_next;
    logic [TIME_W-1:0]      tat_reg, tat_next;
    logic [TIME_W-1:0]      wait_reg, wait_next;
    logic                   last_reg, last_next;

    sjf_entry_t             mem [MAX_PROCS];
    sjf_entry_t             rd_data_reg;
    logic                   mem_we, mem_re;
    logic [IDX_W-1:0]       rd_addr;

    logic                   in_fire;
    logic                   out_free;
    logic [TIME_W-1:0]      arr_ext, bur_ext;
    logic [TIME_W-1:0]      comp_val, wait_val;

    assign s_ready = (state_reg == ST_LOAD);
    assign in_fire = s_valid && s_ready;
    assign mem_we  = in_fire && (loaded_reg < CNT_W'(MAX_PROCS));
    assign mem_re  = (state_reg == ST_SCAN) && (issue_reg < loaded_reg);
    assign rd_addr = issue_reg[IDX_W-1:0];
    assign out_free = !m_valid_reg || m_ready;

    assign arr_ext  = TIME_W'(best_arr_reg);
    assign bur_ext  = TIME_W'(best_bur_reg);
    assign comp_val = time_reg + bur_ext;
    // waiting time = start - arrival, so turnaround = waiting + burst
    assign wait_val = time_reg - arr_ext;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[loaded_reg[IDX_W-1:0]] <= '{arrival: s_arrival_time, burst: s_burst_time};
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        finished_next = finished_reg;
        time_next     = time_reg;
        done_next     = done_reg;
        issue_next    = issue_reg;
        rd_vld_next   = mem_re;
        rd_idx_next   = rd_addr;
        found_next    = found_reg;
        any_next      = any_reg;
        pick_next     = pick_reg;
        best_bur_next = best_bur_reg;
        best_arr_next = best_arr_reg;
        earliest_next = earliest_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        pidx_next     = pidx_reg;
        comp_next     = comp_reg;
        tat_next      = tat_reg;
        wait_next     = wait_reg;
        last_next     = last_reg;

        // evaluate the entry read in the previous cycle
        if (rd_vld_reg && !done_reg[rd_idx_reg]) begin
            if (!any_reg || rd_data_reg.arrival < earliest_reg) begin
                earliest_next = rd_data_reg.arrival;
                any_next      = 1'b1;
            end
            if ((TIME_W'(rd_data_reg.arrival) <= time_reg) &&
                (!found_reg || rd_data_reg.burst < best_bur_reg)) begin
                found_next    = 1'b1;
                pick_next     = rd_idx_reg;
                best_bur_next = rd_data_reg.burst;
                best_arr_next = rd_data_reg.arrival;
            end
        end

        case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    if (mem_we) begin
                        loaded_next = loaded_reg + 1'b1;
                    end
                    if (s_last_process) begin
                        state_next = ST_SCAN;
                        issue_next = '0;
                        found_next = 1'b0;
                        any_next   = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (mem_re) begin
                    issue_next = issue_reg + 1'b1;
                end else if (!rd_vld_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!found_reg) begin
                    // nothing has arrived: jump to the earliest pending arrival
                    time_next  = TIME_W'(earliest_reg);
                    state_next = ST_SCAN;
                    issue_next = '0;
                    any_next   = 1'b0;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    pidx_next    = PIDX_W'(pick_reg);
                    comp_next    = comp_val;
                    wait_next    = wait_val;
                    tat_next     = wait_val + bur_ext;
                    last_next    = ((finished_reg + 1'b1) == loaded_reg);
                    issue_next   = '0;
                    found_next   = 1'b0;
                    any_next     = 1'b0;
                    if ((finished_reg + 1'b1) == loaded_reg) begin
                        state_next    = ST_LOAD;
                        loaded_next   = '0;
                        finished_next = '0;
                        time_next     = '0;
                        done_next     = '0;
                    end else begin
                        state_next          = ST_SCAN;
                        finished_next       = finished_reg + 1'b1;
                        time_next           = comp_val;
                        done_next[pick_reg] = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            loaded_reg   <= '0;
            finished_reg <= '0;
            time_reg     <= '0;
            done_reg     <= '0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            any_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            finished_reg <= finished_next;
            time_reg     <= time_next;
            done_reg     <= done_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            found_reg    <= found_next;
            any_reg      <= any_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        pick_reg     <= pick_next;
        best_bur_reg <= best_bur_next;
        best_arr_reg <= best_arr_next;
        earliest_reg <= earliest_next;
        pidx_reg     <= pidx_next;
        comp_reg     <= comp_next;
        tat_reg      <= tat_next;
        wait_reg     <= wait_next;
        last_reg     <= last_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_process_index   = pidx_reg;
    assign m_completion_time = comp_reg;
    assign m_turnaround_time = tat_reg;
    assign m_waiting_time    = wait_reg;
    assign m_last_result     = last_reg;

endmodule

/* sim/tb_nonpreemptive_sjf_scheduler_unit.sv */
// Testbench for nonpreemptive_sjf_scheduler_unit: loads process sets over the input
// channel and checks every scheduled result against a local shortest-job-first predictor.
// Depends on sjf_pkg and the scheduler RTL.
module tb_nonpreemptive_sjf_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sjf_pkg::*;

    localparam int RAND_WORDS   = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 60;   // accepted words before the long output stall
    localparam int DRAIN_CYCLES = 200;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [TIME_W-1:0]  tick_t;

    typedef struct packed {
        logic [PIDX_W-1:0] pidx;
        tick_t             completion;
        tick_t             turnaround;
        tick_t             waiting;
        logic              last;
    } sched_result_t;

    typedef enum int {
        MIX_DENSE,       // early arrivals, short bursts: ties and overlap
        MIX_WIDE,        // full range on both fields
        MIX_LATE_SHORT,  // any arrival, short bursts: idle jumps
        MIX_HIGH_END     // arrivals near the top, any burst
    } set_mix_t;

    class sjf_scoreboard;
        field_t          arrival_tab[MAX_PROCS];
        field_t          burst_tab[MAX_PROCS];
        int              loaded;
        sched_result_t   schedule_q[$];
        int              errors;
        int              checked;

        function new();
            loaded  = 0;
            errors  = 0;
            checked = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // Store the word; a last word runs the whole schedule for the set.
        function void note_word(field_t arr, field_t bur, logic last);
            bit            done[MAX_PROCS];
            tick_t         now;
            int            finished;
            bit            found;
            bit            waiting_any;
            int            pick;
            field_t        best;
            field_t        earliest;
            sched_result_t r;

            if (loaded < MAX_PROCS) begin
                arrival_tab[loaded] = arr;
                burst_tab[loaded]   = bur;
                loaded++;
            end
            if (!last)
                return;

            now      = '0;
            finished = 0;
            foreach (done[i])
                done[i] = 1'b0;
            while (finished < loaded) begin
                found       = 1'b0;
                waiting_any = 1'b0;
                pick        = 0;
                best        = '0;
                earliest    = '0;
                for (int i = 0; i < loaded; i++) begin
                    if (done[i])
                        continue;
                    if (!waiting_any || arrival_tab[i] < earliest) begin
                        earliest    = arrival_tab[i];
                        waiting_any = 1'b1;
                    end
                    if (tick_t'(arrival_tab[i]) <= now && (!found || burst_tab[i] < best)) begin
                        found = 1'b1;
                        pick  = i;
                        best  = burst_tab[i];
                    end
                end
                if (!found) begin
                    // nothing has arrived yet: jump to the next arrival
                    now = tick_t'(earliest);
                    continue;
                end
                done[pick] = 1'b1;
                finished++;
                r.pidx       = PIDX_W'(pick);
                r.completion = now + tick_t'(best);
                r.turnaround = r.completion - tick_t'(arrival_tab[pick]);
                r.waiting    = r.turnaround - tick_t'(best);
                r.last       = (finished == loaded);
                now          = r.completion;
                schedule_q.push_back(r);
            end
            loaded = 0;
        endfunction

        task check_result(sched_result_t got);
            sched_result_t want;
            if (schedule_q.size() == 0) begin
                report($sformatf("result for process %0d with none expected", got.pidx));
                return;
            end
            want = schedule_q.pop_front();
            checked++;
            if (got.pidx != want.pidx)
                report($sformatf("index %0d, expected %0d", got.pidx, want.pidx));
            if (got.completion != want.completion)
                report($sformatf("process %0d completion %0d, expected %0d",
                                 want.pidx, got.completion, want.completion));
            if (got.turnaround != want.turnaround)
                report($sformatf("process %0d turnaround %0d, expected %0d",
                                 want.pidx, got.turnaround, want.turnaround));
            if (got.waiting != want.waiting)
                report($sformatf("process %0d waiting %0d, expected %0d",
                                 want.pidx, got.waiting, want.waiting));
            if (got.last != want.last)
                report($sformatf("process %0d last flag %0b, expected %0b",
                                 want.pidx, got.last, want.last));
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    field_t            s_arrival_time = '0;
    field_t            s_burst_time = '0;
    logic              s_last_process = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [PIDX_W-1:0] m_process_index;
    tick_t             m_completion_time;
    tick_t             m_turnaround_time;
    tick_t             m_waiting_time;
    logic              m_last_result;

    sjf_scoreboard sb = new();
    int            words_sent = 0;
    int            sets_sent = 0;
    int            largest_set = 0;
    bit            no_idle = 1'b0;

    nonpreemptive_sjf_scheduler_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_arrival_time    (s_arrival_time),
        .s_burst_time      (s_burst_time),
        .s_last_process    (s_last_process),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_process_index   (m_process_index),
        .m_completion_time (m_completion_time),
        .m_turnaround_time (m_turnaround_time),
        .m_waiting_time    (m_waiting_time),
        .m_last_result     (m_last_result)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Called at a clock edge; returns at the edge where the word is taken.
    task send_word(field_t arr, field_t bur, logic last);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 23) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_arrival_time <= arr;
        s_burst_time   <= bur;
        s_last_process <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_word(arr, bur, last);
        words_sent++;
        no_idle = (words_sent >= 100 && words_sent < 150);
    endtask

    task send_set(int size, set_mix_t mix);
        field_t arr;
        field_t bur;
        for (int k = 0; k < size; k++) begin
            case (mix)
                MIX_DENSE: begin
                    arr = field_t'($urandom_range(40));
                    bur = field_t'($urandom_range(12));
                end
                MIX_WIDE: begin
                    arr = field_t'($urandom);
                    bur = field_t'($urandom);
                end
                MIX_LATE_SHORT: begin
                    arr = field_t'($urandom);
                    bur = field_t'($urandom_range(8));
                end
                default: begin
                    arr = field_t'($urandom_range(65535, 65500));
                    bur = field_t'($urandom);
                end
            endcase
            send_word(arr, bur, k == size - 1);
        end
        sets_sent++;
        if (size > largest_set)
            largest_set = size;
    endtask

    initial begin
        int rand_words;
        int size;
        int pick;

        rand_words = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single process, zero burst at time zero
        send_word(16'd0, 16'd0, 1'b1);
        // single process at the top of both ranges: idle jump first
        send_word(16'hFFFF, 16'hFFFF, 1'b1);
        // equal bursts, all arrived: lowest index wins
        send_word(16'd0, 16'd5, 1'b0);
        send_word(16'd0, 16'd5, 1'b0);
        send_word(16'd0, 16'd5, 1'b1);
        // gaps between arrivals force time jumps
        send_word(16'd10, 16'd3, 1'b0);
        send_word(16'd100, 16'd2, 1'b0);
        send_word(16'd5, 16'd7, 1'b0);
        send_word(16'd100, 16'd1, 1'b1);
        // long job first, then short ones that arrived meanwhile
        send_word(16'd0, 16'd10, 1'b0);
        send_word(16'd1, 16'd1, 1'b0);
        send_word(16'd2, 16'd1, 1'b0);
        send_word(16'd3, 16'd0, 1'b1);
        // mixed extremes
        send_word(16'hFFFF, 16'd0, 1'b0);
        send_word(16'd0, 16'hFFFF, 1'b0);
        send_word(16'h8000, 16'd1, 1'b0);
        send_word(16'd1, 16'h7FFF, 1'b1);
        sets_sent += 6;

        while (rand_words < RAND_WORDS) begin
            if (sets_sent == 6) begin
                size = MAX_PROCS;
            end else if (sets_sent == 7) begin
                size = MAX_PROCS + 2;   // words beyond a full table are dropped
            end else begin
                pick = $urandom_range(99);
                if (pick < 6)
                    size = MAX_PROCS;
                else if (pick < 10)
                    size = $urandom_range(MAX_PROCS + 3, MAX_PROCS + 1);
                else
                    size = $urandom_range(8, 1);
            end
            send_set(size, set_mix_t'($urandom_range(3)));
            rand_words += size;
        end
        s_valid <= 1'b0;

        while (sb.schedule_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d process sets (%0d words, largest %0d), %0d results checked,",
                 sets_sent, words_sent, largest_set, sb.checked);
        $display("with table overflow, ties, idle jumps and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Receiver: random back-pressure, one long hold-off while input keeps coming.
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (!held && words_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 23);
            end
        end
    end

    always @(posedge aclk) begin
        sched_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.pidx       = m_process_index;
            got.completion = m_completion_time;
            got.turnaround = m_turnaround_time;
            got.waiting    = m_waiting_time;
            got.last       = m_last_result;
            sb.check_result(got);
        end
    end

endmodule

/* sim.f */
hw/rtl/sjf_pkg.sv
hw/rtl/nonpreemptive_sjf_scheduler_unit.sv
sim/tb_nonpreemptive_sjf_scheduler_unit.sv
